// ===== rtl/hdt_pkg.sv =====
package hdt_pkg;

  localparam int STORE_BYTES    = 4096;
  localparam int MAX_ENTRIES    = 128;
  localparam int ENTRY_OVERHEAD = 32;

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int SLOT_W = $clog2(MAX_ENTRIES);
  localparam int LEN_W  = $clog2(STORE_BYTES + 1);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int SIZE_W = $clog2(2 * STORE_BYTES + 2 * ENTRY_OVERHEAD + 1);

  // fixed field widths of the channels
  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 8;
  localparam int OFF_W   = 12;
  localparam int STAT_W  = 2;
  localparam int FLEN_W  = 13;
  localparam int FCNT_W  = 8;
  localparam int FSIZE_W = 13;
  localparam int CFG_W   = 13;

  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_MATCH  = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_TOO_LARGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  key_len;
    logic [LEN_W-1:0]  value_len;
  } desc_t;

endpackage

// ===== rtl/hdt_if.sv =====
interface hdt_in_if;
  logic                        valid;
  logic                        ready;
  logic [hdt_pkg::CMD_W-1:0]   cmd;
  logic [hdt_pkg::BYTE_W-1:0]  data_byte;
  logic                        in_value_part;
  logic                        carries_no_byte;
  logic                        last_byte;
  logic [hdt_pkg::IDX_W-1:0]   entry_index;
  logic [hdt_pkg::OFF_W-1:0]   byte_offset;

  modport source (output valid, cmd, data_byte, in_value_part, carries_no_byte, last_byte,
                  entry_index, byte_offset, input ready);
  modport sink   (input valid, cmd, data_byte, in_value_part, carries_no_byte, last_byte,
                  entry_index, byte_offset, output ready);
endinterface

interface hdt_out_if;
  logic                         valid;
  logic                         ready;
  logic [hdt_pkg::STAT_W-1:0]   status;
  logic [hdt_pkg::IDX_W-1:0]    found_index;
  logic [hdt_pkg::BYTE_W-1:0]   read_byte;
  logic [hdt_pkg::FLEN_W-1:0]   key_length;
  logic [hdt_pkg::FLEN_W-1:0]   value_length;
  logic [hdt_pkg::FCNT_W-1:0]   num_entries;
  logic [hdt_pkg::FSIZE_W-1:0]  table_bytes;

  modport source (output valid, status, found_index, read_byte, key_length, value_length,
                  num_entries, table_bytes, input ready);
  modport sink   (input valid, status, found_index, read_byte, key_length, value_length,
                  num_entries, table_bytes, output ready);
endinterface

// ===== rtl/hdt_ram.sv =====
module hdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== rtl/hpack_dynamic_header_table_unit.sv =====
// channel   dir  transfer when     payload
// in_i      in   valid & ready     cmd, data_byte, in_value_part, carries_no_byte,
//                                  last_byte, entry_index, byte_offset
// out_o     out  valid & ready     status, found_index, read_byte, key_length,
//                                  value_length, num_entries, table_bytes
// cfg       in   cfg_we_i          cfg_wdata_i = max_table_bytes
//
// a streamed byte that does not end its string keeps the unit idle; ready stays high
// insert end: size check, evict if full, add, evict while over limit; too large clears table
// match end: walks entries newest first, comparing lengths then bytes; emits on hit or miss
// read: descriptor read then byte read; stops early when index or offset is out of range
// the result sits in an output register; the sequencer waits only if it is still full
// reset clears all control state; ram contents stay undefined and are never read unwritten
module hpack_dynamic_header_table_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hdt_pkg::CFG_W-1:0]  cfg_wdata_i,
  hdt_in_if.sink                     in_i,
  hdt_out_if.source                  out_o
);

  localparam int ADDR_W = hdt_pkg::ADDR_W;
  localparam int SLOT_W = hdt_pkg::SLOT_W;
  localparam int LEN_W  = hdt_pkg::LEN_W;
  localparam int CNT_W  = hdt_pkg::CNT_W;
  localparam int SIZE_W = hdt_pkg::SIZE_W;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_CHK, S_PRE_SUB, S_INS_ADD, S_LOOP, S_LOOP_SUB,
    S_M_START, S_M_DESC, S_M_CHK, S_M_BCMP, S_R_CHK, S_R_BYTE, S_EMIT
  } state_e;

  state_e state_q, state_d;

  logic [hdt_pkg::CFG_W-1:0] cfg_q;
  logic [SLOT_W-1:0] newest_q, newest_d;
  logic [CNT_W-1:0]  held_q, held_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [ADDR_W-1:0] wp_q, wp_d;
  logic [LEN_W-1:0]  pkl_q, pkl_d, pvl_q, pvl_d;
  logic              povf_q, povf_d;
  logic [LEN_W-1:0]  qkl_q, qkl_d, qvl_q, qvl_d;
  logic              qovf_q, qovf_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [LEN_W-1:0]  j_q, j_d;
  logic              rvp_q, rvp_d;
  logic [hdt_pkg::OFF_W-1:0] roff_q, roff_d;

  logic [hdt_pkg::STAT_W-1:0] res_st_q, res_st_d;
  logic [CNT_W-1:0]  res_fi_q, res_fi_d;
  logic [7:0]        res_rb_q, res_rb_d;
  logic [LEN_W-1:0]  res_kl_q, res_kl_d, res_vl_q, res_vl_d;

  logic              ov_q;
  logic [hdt_pkg::STAT_W-1:0]  ost_q;
  logic [hdt_pkg::IDX_W-1:0]   ofi_q;
  logic [7:0]                  orb_q;
  logic [hdt_pkg::FLEN_W-1:0]  okl_q, ovl_q;
  logic [hdt_pkg::FCNT_W-1:0]  ocnt_q;
  logic [hdt_pkg::FSIZE_W-1:0] osz_q;

  // ram ports
  logic              st_we, st_re, qb_we, qb_re, ds_we, ds_re;
  logic [ADDR_W-1:0] st_waddr, st_raddr, qb_waddr, qb_raddr;
  logic [7:0]        st_rdata, qb_rdata;
  logic [SLOT_W-1:0] ds_waddr, ds_raddr;
  hdt_pkg::desc_t    ds_wdata, ds_rdata;

  logic              acc;
  logic [LEN_W-1:0]  used, qused, ent_n;
  logic [SIZE_W-1:0] limit, total, cost;
  logic [SLOT_W-1:0] oldest_slot;
  logic [LEN_W-1:0]  plen;

  assign in_i.ready = (state_q == S_IDLE);
  assign acc        = in_i.valid && in_i.ready;

  assign used  = pkl_q + pvl_q;
  assign qused = qkl_q + qvl_q;
  assign limit = (SIZE_W'(cfg_q) < SIZE_W'(hdt_pkg::STORE_BYTES)) ? SIZE_W'(cfg_q)
                                                                   : SIZE_W'(hdt_pkg::STORE_BYTES);
  assign total = SIZE_W'(hdt_pkg::ENTRY_OVERHEAD) + SIZE_W'(pkl_q) + SIZE_W'(pvl_q);
  assign cost  = SIZE_W'(hdt_pkg::ENTRY_OVERHEAD) + SIZE_W'(ds_rdata.key_len)
               + SIZE_W'(ds_rdata.value_len);
  assign ent_n = ds_rdata.key_len + ds_rdata.value_len;
  assign oldest_slot = newest_q - held_q[SLOT_W-1:0] + SLOT_W'(1);
  assign plen  = rvp_q ? ds_rdata.value_len : ds_rdata.key_len;

  always_comb begin
    state_d  = state_q;
    newest_d = newest_q;
    held_d   = held_q;
    size_d   = size_q;
    wp_d     = wp_q;
    pkl_d    = pkl_q;
    pvl_d    = pvl_q;
    povf_d   = povf_q;
    qkl_d    = qkl_q;
    qvl_d    = qvl_q;
    qovf_d   = qovf_q;
    i_d      = i_q;
    j_d      = j_q;
    rvp_d    = rvp_q;
    roff_d   = roff_q;
    res_st_d = res_st_q;
    res_fi_d = res_fi_q;
    res_rb_d = res_rb_q;
    res_kl_d = res_kl_q;
    res_vl_d = res_vl_q;

    st_we    = 1'b0;
    st_waddr = wp_q + used[ADDR_W-1:0];
    st_re    = 1'b0;
    st_raddr = ds_rdata.start;
    qb_we    = 1'b0;
    qb_waddr = qused[ADDR_W-1:0];
    qb_re    = 1'b0;
    qb_raddr = '0;
    ds_we    = 1'b0;
    ds_waddr = newest_q + SLOT_W'(1);
    ds_wdata = '{start: wp_q, key_len: pkl_q, value_len: pvl_q};
    ds_re    = 1'b0;
    ds_raddr = oldest_slot;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (in_i.cmd)
            hdt_pkg::CMD_INSERT: begin
              if (!in_i.carries_no_byte && !(!in_i.in_value_part && pvl_q != '0)) begin
                if (used >= LEN_W'(hdt_pkg::STORE_BYTES)) begin
                  povf_d = 1'b1;
                end else begin
                  st_we = 1'b1;
                  if (in_i.in_value_part) pvl_d = pvl_q + LEN_W'(1);
                  else                    pkl_d = pkl_q + LEN_W'(1);
                end
              end
              if (in_i.last_byte) state_d = S_INS_CHK;
            end
            hdt_pkg::CMD_MATCH: begin
              if (!in_i.carries_no_byte && !(!in_i.in_value_part && qvl_q != '0)) begin
                if (qused >= LEN_W'(hdt_pkg::STORE_BYTES)) begin
                  qovf_d = 1'b1;
                end else begin
                  qb_we = 1'b1;
                  if (in_i.in_value_part) qvl_d = qvl_q + LEN_W'(1);
                  else                    qkl_d = qkl_q + LEN_W'(1);
                end
              end
              if (in_i.last_byte) state_d = S_M_START;
            end
            hdt_pkg::CMD_READ: begin
              res_fi_d = '0;
              res_rb_d = '0;
              rvp_d    = in_i.in_value_part;
              roff_d   = in_i.byte_offset;
              if (in_i.entry_index == '0 ||
                  CNT_W'(in_i.entry_index) > held_q ||
                  in_i.entry_index > hdt_pkg::IDX_W'(held_q)) begin
                res_st_d = hdt_pkg::ST_NOT_FOUND;
                res_kl_d = '0;
                res_vl_d = '0;
                state_d  = S_EMIT;
              end else begin
                ds_re    = 1'b1;
                ds_raddr = newest_q - SLOT_W'(in_i.entry_index - hdt_pkg::IDX_W'(1));
                state_d  = S_R_CHK;
              end
            end
            default: ;
          endcase
        end
      end

      S_INS_CHK: begin
        res_fi_d = '0;
        res_rb_d = '0;
        res_kl_d = pkl_q;
        res_vl_d = pvl_q;
        if (povf_q || total > limit) begin
          held_d   = '0;
          size_d   = '0;
          res_st_d = hdt_pkg::ST_TOO_LARGE;
          pkl_d    = '0;
          pvl_d    = '0;
          povf_d   = 1'b0;
          state_d  = S_EMIT;
        end else begin
          res_st_d = hdt_pkg::ST_OK;
          if (held_q >= CNT_W'(hdt_pkg::MAX_ENTRIES)) begin
            ds_re   = 1'b1;
            state_d = S_PRE_SUB;
          end else begin
            state_d = S_INS_ADD;
          end
        end
      end

      S_PRE_SUB: begin
        size_d  = (size_q >= cost) ? size_q - cost : '0;
        held_d  = held_q - CNT_W'(1);
        state_d = S_INS_ADD;
      end

      S_INS_ADD: begin
        ds_we    = 1'b1;
        newest_d = newest_q + SLOT_W'(1);
        wp_d     = wp_q + used[ADDR_W-1:0];
        held_d   = held_q + CNT_W'(1);
        size_d   = size_q + total;
        pkl_d    = '0;
        pvl_d    = '0;
        povf_d   = 1'b0;
        state_d  = S_LOOP;
      end

      S_LOOP: begin
        if (size_q > limit && held_q != '0) begin
          ds_re   = 1'b1;
          state_d = S_LOOP_SUB;
        end else begin
          state_d = S_EMIT;
        end
      end

      S_LOOP_SUB: begin
        size_d  = (size_q >= cost) ? size_q - cost : '0;
        held_d  = held_q - CNT_W'(1);
        state_d = S_LOOP;
      end

      S_M_START: begin
        res_rb_d = '0;
        res_st_d = hdt_pkg::ST_NOT_FOUND;
        res_fi_d = '0;
        res_kl_d = '0;
        res_vl_d = '0;
        i_d      = CNT_W'(1);
        if (qovf_q || held_q == '0) begin
          qkl_d   = '0;
          qvl_d   = '0;
          qovf_d  = 1'b0;
          state_d = S_EMIT;
        end else begin
          state_d = S_M_DESC;
        end
      end

      S_M_DESC: begin
        if (i_q > held_q) begin
          qkl_d   = '0;
          qvl_d   = '0;
          qovf_d  = 1'b0;
          state_d = S_EMIT;
        end else begin
          ds_re    = 1'b1;
          ds_raddr = newest_q - SLOT_W'(i_q - CNT_W'(1));
          state_d  = S_M_CHK;
        end
      end

      S_M_CHK: begin
        if (ds_rdata.key_len == qkl_q && ds_rdata.value_len == qvl_q) begin
          if (ent_n == '0) begin
            res_st_d = hdt_pkg::ST_OK;
            res_fi_d = i_q;
            res_kl_d = ds_rdata.key_len;
            res_vl_d = ds_rdata.value_len;
            qkl_d    = '0;
            qvl_d    = '0;
            qovf_d   = 1'b0;
            state_d  = S_EMIT;
          end else begin
            st_re    = 1'b1;
            qb_re    = 1'b1;
            qb_raddr = '0;
            j_d      = '0;
            state_d  = S_M_BCMP;
          end
        end else begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_M_DESC;
        end
      end

      S_M_BCMP: begin
        if (st_rdata != qb_rdata) begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_M_DESC;
        end else if (j_q + LEN_W'(1) == ent_n) begin
          res_st_d = hdt_pkg::ST_OK;
          res_fi_d = i_q;
          res_kl_d = ds_rdata.key_len;
          res_vl_d = ds_rdata.value_len;
          qkl_d    = '0;
          qvl_d    = '0;
          qovf_d   = 1'b0;
          state_d  = S_EMIT;
        end else begin
          // next byte pair is fetched while this one is compared
          j_d      = j_q + LEN_W'(1);
          st_re    = 1'b1;
          st_raddr = ds_rdata.start + ADDR_W'(j_q + LEN_W'(1));
          qb_re    = 1'b1;
          qb_raddr = ADDR_W'(j_q + LEN_W'(1));
        end
      end

      S_R_CHK: begin
        res_kl_d = ds_rdata.key_len;
        res_vl_d = ds_rdata.value_len;
        if (LEN_W'(roff_q) >= plen) begin
          res_st_d = hdt_pkg::ST_NOT_FOUND;
          state_d  = S_EMIT;
        end else begin
          st_re    = 1'b1;
          st_raddr = ds_rdata.start + (rvp_q ? ADDR_W'(ds_rdata.key_len) : '0)
                   + ADDR_W'(roff_q);
          state_d  = S_R_BYTE;
        end
      end

      S_R_BYTE: begin
        res_st_d = hdt_pkg::ST_OK;
        res_rb_d = st_rdata;
        state_d  = S_EMIT;
      end

      S_EMIT: begin
        if (!ov_q || out_o.ready) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cfg_q    <= hdt_pkg::CFG_RESET;
      newest_q <= '0;
      held_q   <= '0;
      size_q   <= '0;
      wp_q     <= '0;
      pkl_q    <= '0;
      pvl_q    <= '0;
      povf_q   <= 1'b0;
      qkl_q    <= '0;
      qvl_q    <= '0;
      qovf_q   <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      rvp_q    <= 1'b0;
      roff_q   <= '0;
      res_st_q <= '0;
      res_fi_q <= '0;
      res_rb_q <= '0;
      res_kl_q <= '0;
      res_vl_q <= '0;
      ov_q     <= 1'b0;
      ost_q    <= '0;
      ofi_q    <= '0;
      orb_q    <= '0;
      okl_q    <= '0;
      ovl_q    <= '0;
      ocnt_q   <= '0;
      osz_q    <= '0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      newest_q <= newest_d;
      held_q   <= held_d;
      size_q   <= size_d;
      wp_q     <= wp_d;
      pkl_q    <= pkl_d;
      pvl_q    <= pvl_d;
      povf_q   <= povf_d;
      qkl_q    <= qkl_d;
      qvl_q    <= qvl_d;
      qovf_q   <= qovf_d;
      i_q      <= i_d;
      j_q      <= j_d;
      rvp_q    <= rvp_d;
      roff_q   <= roff_d;
      res_st_q <= res_st_d;
      res_fi_q <= res_fi_d;
      res_rb_q <= res_rb_d;
      res_kl_q <= res_kl_d;
      res_vl_q <= res_vl_d;
      if (state_q == S_EMIT && (!ov_q || out_o.ready)) begin
        ov_q   <= 1'b1;
        ost_q  <= res_st_q;
        ofi_q  <= hdt_pkg::IDX_W'(res_fi_q);
        orb_q  <= res_rb_q;
        okl_q  <= hdt_pkg::FLEN_W'(res_kl_q);
        ovl_q  <= hdt_pkg::FLEN_W'(res_vl_q);
        ocnt_q <= hdt_pkg::FCNT_W'(held_q);
        osz_q  <= hdt_pkg::FSIZE_W'(size_q);
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.status       = ost_q;
  assign out_o.found_index  = ofi_q;
  assign out_o.read_byte    = orb_q;
  assign out_o.key_length   = okl_q;
  assign out_o.value_length = ovl_q;
  assign out_o.num_entries  = ocnt_q;
  assign out_o.table_bytes  = osz_q;

  hdt_ram #(.WIDTH(8), .DEPTH(hdt_pkg::STORE_BYTES)) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (st_we),
    .wr_addr_i (st_waddr),
    .wr_data_i (in_i.data_byte),
    .rd_en_i   (st_re),
    .rd_addr_i (st_raddr),
    .rd_data_o (st_rdata)
  );

  hdt_ram #(.WIDTH(8), .DEPTH(hdt_pkg::STORE_BYTES)) u_query (
    .clk_i     (clk_i),
    .wr_en_i   (qb_we),
    .wr_addr_i (qb_waddr),
    .wr_data_i (in_i.data_byte),
    .rd_en_i   (qb_re),
    .rd_addr_i (qb_raddr),
    .rd_data_o (qb_rdata)
  );

  hdt_ram #(.WIDTH($bits(hdt_pkg::desc_t)), .DEPTH(hdt_pkg::MAX_ENTRIES)) u_desc (
    .clk_i     (clk_i),
    .wr_en_i   (ds_we),
    .wr_addr_i (ds_waddr),
    .wr_data_i (ds_wdata),
    .rd_en_i   (ds_re),
    .rd_addr_i (ds_raddr),
    .rd_data_o (ds_rdata)
  );

endmodule

// ===== rtl/hdt_checker.sv =====
module hdt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [hdt_pkg::STAT_W-1:0]   status_i,
  input logic [hdt_pkg::IDX_W-1:0]    found_index_i,
  input logic [hdt_pkg::FCNT_W-1:0]   num_entries_i,
  input logic [hdt_pkg::FSIZE_W-1:0]  table_bytes_i
);

  // a pending result is held until its transfer
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i))
    else $error("result dropped or changed while stalled");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> num_entries_i <= hdt_pkg::FCNT_W'(hdt_pkg::MAX_ENTRIES))
    else $error("entry count above capacity");

  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> table_bytes_i <= hdt_pkg::FSIZE_W'(hdt_pkg::STORE_BYTES))
    else $error("accounted size above store");

  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && found_index_i != '0 |->
      status_i == hdt_pkg::ST_OK && found_index_i <= num_entries_i)
    else $error("match index inconsistent");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == hdt_pkg::ST_TOO_LARGE |->
      num_entries_i == '0 && table_bytes_i == '0)
    else $error("oversized insert left entries");

endmodule

bind hpack_dynamic_header_table_unit hdt_checker u_hdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .found_index_i (out_o.found_index),
  .num_entries_i (out_o.num_entries),
  .table_bytes_i (out_o.table_bytes)
);
